// ===== hdl/pvc_pkg.sv =====
`default_nettype none

package pvc_pkg;

  localparam int unsigned KEY_DEPTH = 64;
  localparam int unsigned KeyAw     = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int unsigned KeyLw     = $clog2(KEY_DEPTH + 1);
  localparam int unsigned IdxW      = 6;
  localparam logic [IdxW-1:0] AlphaLen = IdxW'(33);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_KEY   = 2'd1,
    OP_TEXT  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_CIPHERED    = 3'd0,
    ST_PASSED      = 3'd1,
    ST_KEY_EMPTY   = 3'd2,
    ST_KEY_STORED  = 3'd3,
    ST_KEY_IGNORED = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] symbol_code;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_code;
    logic [2:0]  status;
  } out_item_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
  } letter_t;

  function automatic letter_t letter_index(input logic [15:0] code);
    logic [15:0] cp;
    letter_t     res;
    cp        = code;
    res.valid = 1'b0;
    res.idx   = '0;
    if (cp inside {[16'h0430:16'h044F]}) begin
      cp = cp - 16'h0020;
    end else if (cp == 16'h0451) begin
      cp = 16'h0401;
    end
    if (cp == 16'h0401) begin
      res.valid = 1'b1;
      res.idx   = IdxW'(6);
    end else if (cp inside {[16'h0410:16'h0415]}) begin
      res.valid = 1'b1;
      res.idx   = IdxW'(cp - 16'h0410);
    end else if (cp inside {[16'h0416:16'h042F]}) begin
      res.valid = 1'b1;
      res.idx   = IdxW'(cp - 16'h040F);
    end
    return res;
  endfunction

  function automatic logic [15:0] letter_code(input logic [IdxW-1:0] idx);
    logic [15:0] res;
    if (idx < IdxW'(6)) begin
      res = 16'h0410 + 16'(idx);
    end else if (idx == IdxW'(6)) begin
      res = 16'h0401;
    end else begin
      res = 16'h040F + 16'(idx);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/progressive_vigenere_cipher_unit.sv =====
// channel | valid      | stall       | payload
// input   | in_valid_i | in_stall_o  | in_item_i  (opcode, symbol_code)
// output  | out_valid_o| out_stall_i | out_item_o (out_code, status)
// config  | cfg_we_i   | -           | cfg_wdata_i (direction)
// One item per cycle while out_stall_i is low; an accepted item is held in in_q,
// then registered in out_q. Key memory read is registered, its address taken
// from the next key position with write bypass. Reset clears counters,
// direction and valids only; key entries are never read before written.
// A stalled output holds one item while the input register still takes one more.
`default_nettype none

module progressive_vigenere_cipher_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pvc_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pvc_pkg::out_item_t      out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i
);

  logic                         dir_q;
  logic                         in_valid_q;
  pvc_pkg::in_item_t            in_q;
  logic                         out_valid_q;
  pvc_pkg::out_item_t           out_q, out_d;
  logic [pvc_pkg::KeyLw-1:0]    key_len_q, key_len_d;
  logic [pvc_pkg::KeyAw-1:0]    key_pos_q, key_pos_d;
  logic [pvc_pkg::IdxW-1:0]     level_q, level_d;
  logic [pvc_pkg::IdxW-1:0]     key_mem [pvc_pkg::KEY_DEPTH];
  logic [pvc_pkg::IdxW-1:0]     key_rd_q;
  logic                         process;
  logic                         accept;
  logic                         key_we;
  pvc_pkg::letter_t             letter;
  logic [pvc_pkg::IdxW:0]       shift_sum;
  logic [pvc_pkg::IdxW-1:0]     shift;
  logic [pvc_pkg::IdxW:0]       res_sum;
  logic [pvc_pkg::IdxW-1:0]     res_idx;
  logic [pvc_pkg::KeyLw-1:0]    pos_inc;

  assign process     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !process;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign letter      = pvc_pkg::letter_index(in_q.symbol_code);

  always_comb begin
    shift_sum = {1'b0, key_rd_q} + {1'b0, level_q};
    if (shift_sum >= {1'b0, pvc_pkg::AlphaLen}) begin
      shift_sum = shift_sum - {1'b0, pvc_pkg::AlphaLen};
    end
    shift = shift_sum[pvc_pkg::IdxW-1:0];
    if (dir_q) begin
      res_sum = {1'b0, letter.idx} + {1'b0, pvc_pkg::AlphaLen} - {1'b0, shift};
    end else begin
      res_sum = {1'b0, letter.idx} + {1'b0, shift};
    end
    if (res_sum >= {1'b0, pvc_pkg::AlphaLen}) begin
      res_sum = res_sum - {1'b0, pvc_pkg::AlphaLen};
    end
    res_idx = res_sum[pvc_pkg::IdxW-1:0];
  end

  always_comb begin
    key_len_d    = key_len_q;
    key_pos_d    = key_pos_q;
    level_d      = level_q;
    key_we       = 1'b0;
    out_d.out_code = '0;
    out_d.status   = pvc_pkg::ST_KEY_IGNORED;
    pos_inc      = pvc_pkg::KeyLw'(key_pos_q) + pvc_pkg::KeyLw'(1);
    if (process) begin
      case (in_q.opcode)
        pvc_pkg::OP_CLEAR: begin
          key_len_d    = '0;
          key_pos_d    = '0;
          level_d      = '0;
          out_d.status = pvc_pkg::ST_KEY_EMPTY;
        end
        pvc_pkg::OP_KEY: begin
          if (letter.valid && key_len_q < pvc_pkg::KeyLw'(pvc_pkg::KEY_DEPTH)) begin
            key_we       = 1'b1;
            key_len_d    = key_len_q + pvc_pkg::KeyLw'(1);
            out_d.status = pvc_pkg::ST_KEY_STORED;
          end
        end
        pvc_pkg::OP_TEXT: begin
          if (key_len_q == '0) begin
            out_d.status = pvc_pkg::ST_KEY_EMPTY;
          end else if (letter.valid) begin
            out_d.out_code = pvc_pkg::letter_code(res_idx);
            out_d.status   = pvc_pkg::ST_CIPHERED;
            if (pos_inc >= key_len_q) begin
              key_pos_d = '0;
              level_d   = (level_q == pvc_pkg::AlphaLen - pvc_pkg::IdxW'(1)) ?
                          '0 : level_q + pvc_pkg::IdxW'(1);
            end else begin
              key_pos_d = pos_inc[pvc_pkg::KeyAw-1:0];
            end
          end else begin
            out_d.out_code = in_q.symbol_code;
            out_d.status   = pvc_pkg::ST_PASSED;
          end
        end
        default: begin
          out_d.status = pvc_pkg::ST_KEY_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= 1'b0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      key_len_q   <= '0;
      key_pos_q   <= '0;
      level_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
      end
      in_valid_q  <= accept || (in_valid_q && !process);
      out_valid_q <= process || (out_valid_q && out_stall_i);
      key_len_q   <= key_len_d;
      key_pos_q   <= key_pos_d;
      level_q     <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_item_i;
    end
    if (process) begin
      out_q <= out_d;
    end
  end

  // key memory, read data tracks the next key position
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_len_q[pvc_pkg::KeyAw-1:0]] <= letter.idx;
    end
    if (key_we && key_len_q[pvc_pkg::KeyAw-1:0] == key_pos_d) begin
      key_rd_q <= letter.idx;
    end else begin
      key_rd_q <= key_mem[key_pos_d];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pvc_checker.sv =====
`default_nettype none

module pvc_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire pvc_pkg::out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transfer dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled output payload changed");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output register");

  a_cipher_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == pvc_pkg::ST_CIPHERED |->
      out_item_o.out_code == 16'h0401 ||
      (out_item_o.out_code >= 16'h0410 && out_item_o.out_code <= 16'h042F))
    else $error("ciphered result is not an uppercase letter");

  a_key_zero_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == pvc_pkg::ST_KEY_EMPTY ||
      out_item_o.status == pvc_pkg::ST_KEY_STORED ||
      out_item_o.status == pvc_pkg::ST_KEY_IGNORED) |->
      out_item_o.out_code == 16'h0000)
    else $error("non-text result carries a code");

endmodule

bind progressive_vigenere_cipher_unit pvc_checker u_pvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== tb/progressive_vigenere_cipher_unit_test.sv =====
`default_nettype none

module progressive_vigenere_cipher_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned AlphaSize = 33;
  localparam int unsigned MaxReports = 10;

  typedef struct {
    logic [1:0]         op;
    logic [15:0]        code;
    bit                 typed;
    pvc_pkg::out_item_t want;
  } script_row_t;

  logic               clk_i = 1'b1;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  pvc_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  pvc_pkg::out_item_t out_item_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_wdata_i = 1'b0;

  bit                 row_typed = 1'b0;
  pvc_pkg::out_item_t row_want = '0;

  logic [15:0] glyph [0:32] = '{
    16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0401, 16'h0416,
    16'h0417, 16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E,
    16'h041F, 16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426,
    16'h0427, 16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E,
    16'h042F
  };

  logic [5:0]  key_mem [pvc_pkg::KEY_DEPTH];
  int unsigned key_len = 0;
  int unsigned key_pos = 0;
  int unsigned level = 0;
  bit          decrypting = 1'b0;

  pvc_pkg::out_item_t cipher_queue [$];
  int unsigned faults = 0;
  int unsigned sent = 0;
  int unsigned feed_odds = 0;
  int unsigned drain_odds = 0;
  int unsigned hold_left = 0;

  script_row_t script [21] = '{
    '{pvc_pkg::OP_TEXT,  16'h0410, 1'b1, {16'h0000, pvc_pkg::ST_KEY_EMPTY}},
    '{pvc_pkg::OP_KEY,   16'h0041, 1'b1, {16'h0000, pvc_pkg::ST_KEY_IGNORED}},
    '{OpUnused,          16'hFFFF, 1'b1, {16'h0000, pvc_pkg::ST_KEY_IGNORED}},
    '{pvc_pkg::OP_CLEAR, 16'h0000, 1'b1, {16'h0000, pvc_pkg::ST_KEY_EMPTY}},
    '{pvc_pkg::OP_KEY,   16'h0430, 1'b1, {16'h0000, pvc_pkg::ST_KEY_STORED}},
    '{pvc_pkg::OP_KEY,   16'h0451, 1'b1, {16'h0000, pvc_pkg::ST_KEY_STORED}},
    '{pvc_pkg::OP_KEY,   16'h042F, 1'b1, {16'h0000, pvc_pkg::ST_KEY_STORED}},
    '{pvc_pkg::OP_TEXT,  16'h0410, 1'b0, '0},
    '{pvc_pkg::OP_TEXT,  16'h044F, 1'b0, '0},
    '{pvc_pkg::OP_TEXT,  16'h0020, 1'b1, {16'h0020, pvc_pkg::ST_PASSED}},
    '{pvc_pkg::OP_TEXT,  16'hFFFF, 1'b1, {16'hFFFF, pvc_pkg::ST_PASSED}},
    '{pvc_pkg::OP_TEXT,  16'h0000, 1'b1, {16'h0000, pvc_pkg::ST_PASSED}},
    '{pvc_pkg::OP_TEXT,  16'h0401, 1'b0, '0},
    '{pvc_pkg::OP_KEY,   16'h041F, 1'b1, {16'h0000, pvc_pkg::ST_KEY_STORED}},
    '{pvc_pkg::OP_TEXT,  16'h0416, 1'b0, '0},
    '{pvc_pkg::OP_TEXT,  16'h0415, 1'b0, '0},
    '{pvc_pkg::OP_TEXT,  16'h040F, 1'b1, {16'h040F, pvc_pkg::ST_PASSED}},
    '{pvc_pkg::OP_TEXT,  16'h0450, 1'b1, {16'h0450, pvc_pkg::ST_PASSED}},
    '{pvc_pkg::OP_TEXT,  16'h0452, 1'b1, {16'h0452, pvc_pkg::ST_PASSED}},
    '{pvc_pkg::OP_CLEAR, 16'hFFFF, 1'b1, {16'h0000, pvc_pkg::ST_KEY_EMPTY}},
    '{pvc_pkg::OP_TEXT,  16'h0430, 1'b1, {16'h0000, pvc_pkg::ST_KEY_EMPTY}}
  };

  progressive_vigenere_cipher_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic bit to_index(input logic [15:0] code, output logic [5:0] idx);
    logic [15:0] cp;
    cp  = code;
    idx = '0;
    if (cp >= 16'h0430 && cp <= 16'h044F) begin
      cp = cp - 16'h0020;
    end else if (cp == 16'h0451) begin
      cp = 16'h0401;
    end
    for (int i = 0; i < AlphaSize; i++) begin
      if (glyph[i] == cp) begin
        idx = 6'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic pvc_pkg::out_item_t cipher_step(input pvc_pkg::in_item_t it);
    pvc_pkg::out_item_t res;
    logic [5:0]         p;
    int unsigned        shift;
    int unsigned        r;
    res.out_code = '0;
    res.status   = pvc_pkg::ST_KEY_IGNORED;
    case (it.opcode)
      pvc_pkg::OP_CLEAR: begin
        key_len    = 0;
        key_pos    = 0;
        level      = 0;
        res.status = pvc_pkg::ST_KEY_EMPTY;
      end
      pvc_pkg::OP_KEY: begin
        if (to_index(it.symbol_code, p) && key_len < pvc_pkg::KEY_DEPTH) begin
          key_mem[key_len] = p;
          key_len++;
          res.status = pvc_pkg::ST_KEY_STORED;
        end
      end
      pvc_pkg::OP_TEXT: begin
        if (key_len == 0) begin
          res.status = pvc_pkg::ST_KEY_EMPTY;
        end else if (to_index(it.symbol_code, p)) begin
          shift = (key_mem[key_pos] + level) % AlphaSize;
          r = decrypting ? (p + AlphaSize - shift) % AlphaSize : (p + shift) % AlphaSize;
          res.out_code = glyph[r];
          res.status   = pvc_pkg::ST_CIPHERED;
          key_pos++;
          if (key_pos >= key_len) begin
            key_pos = 0;
            level   = (level + 1) % AlphaSize;
          end
        end else begin
          res.out_code = it.symbol_code;
          res.status   = pvc_pkg::ST_PASSED;
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic logic [15:0] any_letter();
    int unsigned r;
    r = $urandom_range(0, 65);
    if (r < 32) begin
      return 16'h0410 + 16'(r);
    end else if (r < 64) begin
      return 16'h0430 + 16'(r - 32);
    end else if (r == 64) begin
      return 16'h0401;
    end
    return 16'h0451;
  endfunction

  function automatic logic [15:0] any_code();
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic int unsigned pick_odds();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      2: return 8;
      default: return 20;
    endcase
  endfunction

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= MaxReports) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  always @(posedge clk_i) begin : watch
    pvc_pkg::out_item_t guess;
    pvc_pkg::out_item_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        decrypting = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_o) begin
        guess = cipher_step(in_item_i);
        cipher_queue = {cipher_queue, row_typed ? row_want : guess};
      end
      if (out_valid_o && !out_stall_i) begin
        if (cipher_queue.size() == 0) begin
          note_fault($sformatf("unexpected transfer code=%h status=%0d",
                               out_item_o.out_code, out_item_o.status));
        end else begin
          want = cipher_queue.pop_front();
          if (out_item_o.out_code !== want.out_code || out_item_o.status !== want.status) begin
            note_fault($sformatf("mismatch code exp=%h act=%h status exp=%0d act=%0d",
                                 want.out_code, out_item_o.out_code,
                                 want.status, out_item_o.status));
          end
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= 1'b0;
      if (drain_odds != 0 && $urandom_range(0, drain_odds) == 0) begin
        hold_left <= $urandom_range(1, 11);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [15:0] code,
                           input bit typed = 1'b0,
                           input pvc_pkg::out_item_t want = '0);
    int unsigned gap;
    @(negedge clk_i);
    if (feed_odds != 0 && $urandom_range(0, feed_odds) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= pvc_pkg::in_item_t'{opcode: op, symbol_code: code};
    row_typed  <= typed;
    row_want   <= want;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cipher_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_direction(input bit dir);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= dir;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic run_message(input bit fill);
    int unsigned keys;
    int unsigned texts;
    if ($urandom_range(0, 5) != 0) begin
      send_item(pvc_pkg::OP_CLEAR, any_code());
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) send_item(pvc_pkg::OP_TEXT, any_letter());
      end
    end
    keys = fill ? pvc_pkg::KEY_DEPTH + $urandom_range(1, 6) : $urandom_range(1, 8);
    repeat (keys) begin
      send_item(pvc_pkg::OP_KEY, ($urandom_range(0, 9) == 0) ? any_code() : any_letter());
    end
    texts = $urandom_range(5, 40);
    repeat (texts) begin
      case ($urandom_range(0, 19))
        0: send_item(OpUnused, any_code());
        1: send_item(pvc_pkg::OP_KEY, any_letter());
        2, 3: send_item(pvc_pkg::OP_TEXT, any_code());
        default: send_item(pvc_pkg::OP_TEXT, any_letter());
      endcase
    end
  endtask

  initial begin
    #400_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    phase = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    set_direction(1'b0);
    foreach (script[i]) begin
      send_item(script[i].op, script[i].code, script[i].typed, script[i].want);
    end
    while (sent < 480) begin
      phase++;
      set_direction(phase[0]);
      feed_odds  = pick_odds();
      drain_odds = pick_odds();
      run_message(phase % 8 == 1);
    end
    feed_odds  = 0;
    drain_odds = 0;
    set_direction(1'b1);
    run_message(1'b0);
    drain();
    if (faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
